// ===== rtl/core/rbfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfc_pkg
// Shared types and constants of the rectangle blit/fill clipper: field
// widths, command and register codes, the signed span type used for
// clipping and the stage enables handed to the per-axis clipper.
// ----------------------------------------------------------------------------
package rbfc_pkg;

    // Field widths
    localparam int DIM_W    = 11;   // surface sizes, clipped coordinates and sizes
    localparam int COORD_W  = 12;   // signed input coordinates
    localparam int SPAN_W   = 14;   // signed working width of the clipping arithmetic
    localparam int BPP_W    = 3;
    localparam int OFFS_W   = 22;
    localparam int ROW_W    = 13;
    localparam int COLOR_W  = 32;
    localparam int CFG_IDX_W = 3;

    // Surface sizes written above this value saturate to it
    localparam int MAX_DIM = 1024;

    // Command codes
    localparam logic CMD_BLIT = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BOUNDS  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BPP        = 3'd4;

    typedef logic signed [SPAN_W-1:0] span_t;
    typedef logic [DIM_W-1:0]         dim_t;

    // Load enables of the three clipping stages
    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } stage_en_t;

endpackage

// ===== rtl/core/rbfc_axis_clip.sv =====
// ----------------------------------------------------------------------------
// rbfc_axis_clip
// Three-stage clipper for one axis. Stage 1 picks the operands, checks a
// fill rectangle and clips a negative source coordinate; stage 2 clips
// against the source extent and a negative destination coordinate; stage 3
// clips against the destination extent and flags a positive length.
// ----------------------------------------------------------------------------
module rbfc_axis_clip (
    input  logic                                  aclk,
    input  rbfc_pkg::stage_en_t                   en,
    input  logic                                  is_fill,
    input  logic                                  has_src,
    input  logic                                  has_dst,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   in_s,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   in_d,
    input  logic [rbfc_pkg::DIM_W-1:0]            in_len,
    input  logic [rbfc_pkg::DIM_W-1:0]            surf_s,
    input  logic [rbfc_pkg::DIM_W-1:0]            surf_d,
    output logic [rbfc_pkg::DIM_W-1:0]            pos_s,
    output logic [rbfc_pkg::DIM_W-1:0]            pos_d,
    output logic [rbfc_pkg::DIM_W-1:0]            len,
    output logic                                  len_pos,
    output logic                                  fill_err
);

    localparam int PAD_W = rbfc_pkg::SPAN_W - rbfc_pkg::DIM_W;

    rbfc_pkg::span_t ext_s;
    rbfc_pkg::span_t ext_d;
    rbfc_pkg::span_t ext_len;
    rbfc_pkg::span_t ext_surf_s;
    rbfc_pkg::span_t ext_surf_d;

    rbfc_pkg::span_t s0, l0, d0;
    rbfc_pkg::span_t s1_next, l1_next, d1_next;
    logic            err1_next;
    rbfc_pkg::span_t s1_reg, l1_reg, d1_reg;
    logic            fill1_reg, err1_reg;

    rbfc_pkg::span_t la;
    rbfc_pkg::span_t s2_next, l2_next, d2_next;
    rbfc_pkg::span_t s2_reg, l2_reg, d2_reg;
    logic            fill2_reg, err2_reg;

    rbfc_pkg::span_t l3_next;
    logic [rbfc_pkg::DIM_W-1:0] pos_s_reg, pos_d_reg, len_reg;
    logic            len_pos_reg, err3_reg;

    assign ext_s      = rbfc_pkg::span_t'(in_s);
    assign ext_d      = rbfc_pkg::span_t'(in_d);
    assign ext_len    = {{PAD_W{1'b0}}, in_len};
    assign ext_surf_s = {{PAD_W{1'b0}}, surf_s};
    assign ext_surf_d = {{PAD_W{1'b0}}, surf_d};

    // Stage 1: operand selection, fill bounds check, negative source corner
    always_comb begin
        s0 = '0;
        d0 = '0;
        l0 = is_fill ? ext_surf_d : ext_surf_s;
        if (is_fill) begin
            if (has_dst) begin
                d0 = ext_d;
                l0 = ext_len;
            end
        end else begin
            if (has_src) begin
                s0 = ext_s;
                l0 = ext_len;
            end
            if (has_dst) begin
                d0 = ext_d;
            end
        end
        err1_next = is_fill && has_dst && ((d0 < 0) || (d0 + l0 > ext_surf_d));
        s1_next = s0;
        l1_next = l0;
        d1_next = d0;
        if (!is_fill && (s0 < 0)) begin
            l1_next = l0 + s0;
            d1_next = d0 - s0;
            s1_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.st1) begin
            s1_reg    <= s1_next;
            l1_reg    <= l1_next;
            d1_reg    <= d1_next;
            fill1_reg <= is_fill;
            err1_reg  <= err1_next;
        end
    end

    // Stage 2: source extent, negative destination corner
    always_comb begin
        la = l1_reg;
        if (s1_reg + l1_reg > ext_surf_s) begin
            la = ext_surf_s - s1_reg;
        end
        s2_next = s1_reg;
        l2_next = l1_reg;
        d2_next = d1_reg;
        if (!fill1_reg) begin
            l2_next = la;
            if (d1_reg < 0) begin
                l2_next = la + d1_reg;
                s2_next = s1_reg - d1_reg;
                d2_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.st2) begin
            s2_reg    <= s2_next;
            l2_reg    <= l2_next;
            d2_reg    <= d2_next;
            fill2_reg <= fill1_reg;
            err2_reg  <= err1_reg;
        end
    end

    // Stage 3: destination extent
    always_comb begin
        l3_next = l2_reg;
        if (!fill2_reg && (d2_reg + l2_reg > ext_surf_d)) begin
            l3_next = ext_surf_d - d2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.st3) begin
            pos_s_reg   <= s2_reg[rbfc_pkg::DIM_W-1:0];
            pos_d_reg   <= d2_reg[rbfc_pkg::DIM_W-1:0];
            len_reg     <= l3_next[rbfc_pkg::DIM_W-1:0];
            len_pos_reg <= (l3_next > 0);
            err3_reg    <= err2_reg;
        end
    end

    assign pos_s    = pos_s_reg;
    assign pos_d    = pos_d_reg;
    assign len      = len_reg;
    assign len_pos  = len_pos_reg;
    assign fill_err = err3_reg;

endmodule

// ===== rtl/core/rect_blit_fill_clipper.sv =====
// ----------------------------------------------------------------------------
// rect_blit_fill_clipper
// Command front end of a 2D blit/fill engine: clips blit rectangles against
// both surfaces, checks fill rectangles and works out byte offsets, row
// length and fill pattern.
// ----------------------------------------------------------------------------
// The block takes one command per clock while s_ready is high and returns one
// result per command, in order. It is a five-stage pipeline: three clipping
// stages, a stage holding the row-times-width and width-times-pixel-size
// multipliers, and an output stage that adds the column and scales by the
// pixel size. Each stage loads whenever its successor can take its contents,
// so bubbles close up under back-pressure and a held result does not block
// new commands while earlier stages have room. Surface registers are to be
// written through the cfg_ port only while no command is in flight; the block
// does not enforce this. Sizes above 1024 saturate.
// ----------------------------------------------------------------------------
module rect_blit_fill_clipper (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [rbfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbfc_pkg::DIM_W-1:0]            cfg_data,
    // commands
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_cmd,
    input  logic                                  s_use_src_rect,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_src_x,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_src_y,
    input  logic [rbfc_pkg::DIM_W-1:0]            s_rect_w,
    input  logic [rbfc_pkg::DIM_W-1:0]            s_rect_h,
    input  logic                                  s_use_dst_rect,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_dst_x,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_dst_y,
    input  logic [rbfc_pkg::COLOR_W-1:0]          s_fill_color,
    // results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_status,
    output logic [rbfc_pkg::DIM_W-1:0]            m_out_x,
    output logic [rbfc_pkg::DIM_W-1:0]            m_out_y,
    output logic [rbfc_pkg::DIM_W-1:0]            m_out_w,
    output logic [rbfc_pkg::DIM_W-1:0]            m_out_h,
    output logic [rbfc_pkg::OFFS_W-1:0]           m_src_offset,
    output logic [rbfc_pkg::OFFS_W-1:0]           m_dst_offset,
    output logic [rbfc_pkg::ROW_W-1:0]            m_row_bytes,
    output logic [rbfc_pkg::COLOR_W-1:0]          m_fill_pattern
);

    localparam int DIM_W   = rbfc_pkg::DIM_W;
    localparam int OFFS_W  = rbfc_pkg::OFFS_W;
    localparam int ROW_W   = rbfc_pkg::ROW_W;
    localparam int COLOR_W = rbfc_pkg::COLOR_W;
    localparam int BPP_W   = rbfc_pkg::BPP_W;
    localparam int SAT_W   = DIM_W + 2;

    // Configuration registers
    logic [DIM_W-1:0] src_width_reg, src_height_reg;
    logic [DIM_W-1:0] dst_width_reg, dst_height_reg;
    logic [BPP_W-1:0] bpp_reg;
    logic [DIM_W-1:0] dim_next;

    // Pipeline control
    logic [5:1] valid_reg;
    logic [5:1] load;
    rbfc_pkg::stage_en_t clip_en;

    // Side-band carried alongside the clippers
    logic                fill1_reg, fill2_reg, fill3_reg;
    logic [COLOR_W-1:0]  color1_reg, color2_reg, color3_reg;

    // Clipper outputs
    logic [DIM_W-1:0] sx3, dx3, w3, sy3, dy3, h3;
    logic             wpos3, hpos3, xerr3, yerr3;

    // Stage 4
    logic                drop4_next, err4_next;
    logic [COLOR_W-1:0]  pat4_next;
    logic [2*DIM_W-1:0]  prod_s4_next, prod_d4_next;
    logic [DIM_W+BPP_W-1:0] row4_full;
    logic                status4_reg;
    logic [DIM_W-1:0]    sx4_reg, dx4_reg, dy4_reg, w4_reg, h4_reg;
    logic [OFFS_W-1:0]   prod_s4_reg, prod_d4_reg;
    logic [ROW_W-1:0]    row4_reg;
    logic [COLOR_W-1:0]  pat4_reg;

    // Stage 5
    logic [OFFS_W-1:0]   src_lin, dst_lin;
    logic [OFFS_W-1:0]   src_off_next, dst_off_next;
    logic                status5_reg;
    logic [DIM_W-1:0]    out_x_reg, out_y_reg, out_w_reg, out_h_reg;
    logic [OFFS_W-1:0]   src_off_reg, dst_off_reg;
    logic [ROW_W-1:0]    row5_reg;
    logic [COLOR_W-1:0]  pat5_reg;

    // ---------------------------------------------------------------- config
    always_comb begin
        dim_next = cfg_data;
        if ({2'b00, cfg_data} > SAT_W'(rbfc_pkg::MAX_DIM)) begin
            dim_next = DIM_W'(rbfc_pkg::MAX_DIM);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= DIM_W'(320);
            src_height_reg <= DIM_W'(240);
            dst_width_reg  <= DIM_W'(320);
            dst_height_reg <= DIM_W'(240);
            bpp_reg        <= BPP_W'(4);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rbfc_pkg::REG_SRC_WIDTH:  src_width_reg  <= dim_next;
                rbfc_pkg::REG_SRC_HEIGHT: src_height_reg <= dim_next;
                rbfc_pkg::REG_DST_WIDTH:  dst_width_reg  <= dim_next;
                rbfc_pkg::REG_DST_HEIGHT: dst_height_reg <= dim_next;
                rbfc_pkg::REG_BPP:        bpp_reg        <= cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------- pipeline
    // A stage loads when it is empty or its successor loads this cycle
    always_comb begin
        load[5] = !valid_reg[5] || m_ready;
        load[4] = !valid_reg[4] || load[5];
        load[3] = !valid_reg[3] || load[4];
        load[2] = !valid_reg[2] || load[3];
        load[1] = !valid_reg[1] || load[2];
    end

    assign s_ready     = load[1];
    assign clip_en.st1 = load[1];
    assign clip_en.st2 = load[2];
    assign clip_en.st3 = load[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[1]) valid_reg[1] <= s_valid;
            if (load[2]) valid_reg[2] <= valid_reg[1];
            if (load[3]) valid_reg[3] <= valid_reg[2];
            if (load[4]) valid_reg[4] <= valid_reg[3];
            if (load[5]) valid_reg[5] <= valid_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            fill1_reg  <= (s_cmd == rbfc_pkg::CMD_FILL);
            color1_reg <= s_fill_color;
        end
        if (load[2]) begin
            fill2_reg  <= fill1_reg;
            color2_reg <= color1_reg;
        end
        if (load[3]) begin
            fill3_reg  <= fill2_reg;
            color3_reg <= color2_reg;
        end
    end

    // ------------------------------------------------------- stages 1 to 3
    rbfc_axis_clip u_clip_x (
        .aclk     (aclk),
        .en       (clip_en),
        .is_fill  (s_cmd == rbfc_pkg::CMD_FILL),
        .has_src  (s_use_src_rect),
        .has_dst  (s_use_dst_rect),
        .in_s     (s_src_x),
        .in_d     (s_dst_x),
        .in_len   (s_rect_w),
        .surf_s   (src_width_reg),
        .surf_d   (dst_width_reg),
        .pos_s    (sx3),
        .pos_d    (dx3),
        .len      (w3),
        .len_pos  (wpos3),
        .fill_err (xerr3)
    );

    rbfc_axis_clip u_clip_y (
        .aclk     (aclk),
        .en       (clip_en),
        .is_fill  (s_cmd == rbfc_pkg::CMD_FILL),
        .has_src  (s_use_src_rect),
        .has_dst  (s_use_dst_rect),
        .in_s     (s_src_y),
        .in_d     (s_dst_y),
        .in_len   (s_rect_h),
        .surf_s   (src_height_reg),
        .surf_d   (dst_height_reg),
        .pos_s    (sy3),
        .pos_d    (dy3),
        .len      (h3),
        .len_pos  (hpos3),
        .fill_err (yerr3)
    );

    // --------------------------------------------------------------- stage 4
    // Drop an empty blit or a failed fill to all-zero geometry
    always_comb begin
        err4_next  = fill3_reg && (xerr3 || yerr3);
        drop4_next = fill3_reg ? err4_next : !(wpos3 && hpos3);
        unique case (bpp_reg)
            BPP_W'(0): pat4_next = '0;
            BPP_W'(1): pat4_next = {24'h0, color3_reg[7:0]};
            BPP_W'(2): pat4_next = {16'h0, color3_reg[15:0]};
            BPP_W'(3): pat4_next = {8'h0, color3_reg[23:0]};
            default:   pat4_next = color3_reg;
        endcase
        prod_s4_next = (2*DIM_W)'(sy3) * (2*DIM_W)'(src_width_reg);
        prod_d4_next = (2*DIM_W)'(dy3) * (2*DIM_W)'(dst_width_reg);
        row4_full    = (DIM_W+BPP_W)'(w3) * (DIM_W+BPP_W)'(bpp_reg);
    end

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            status4_reg <= err4_next ? rbfc_pkg::STATUS_BOUNDS : rbfc_pkg::STATUS_OK;
            if (drop4_next) begin
                sx4_reg     <= '0;
                dx4_reg     <= '0;
                dy4_reg     <= '0;
                w4_reg      <= '0;
                h4_reg      <= '0;
                prod_s4_reg <= '0;
                prod_d4_reg <= '0;
                row4_reg    <= '0;
                pat4_reg    <= '0;
            end else begin
                // a fill has no source side
                sx4_reg     <= fill3_reg ? '0 : sx3;
                prod_s4_reg <= fill3_reg ? '0 : OFFS_W'(prod_s4_next);
                dx4_reg     <= dx3;
                dy4_reg     <= dy3;
                w4_reg      <= w3;
                h4_reg      <= h3;
                prod_d4_reg <= OFFS_W'(prod_d4_next);
                row4_reg    <= row4_full[ROW_W-1:0];
                pat4_reg    <= fill3_reg ? pat4_next : '0;
            end
        end
    end

    // --------------------------------------------------------------- stage 5
    always_comb begin
        src_lin      = prod_s4_reg + {{(OFFS_W-DIM_W){1'b0}}, sx4_reg};
        dst_lin      = prod_d4_reg + {{(OFFS_W-DIM_W){1'b0}}, dx4_reg};
        src_off_next = OFFS_W'(src_lin * {{(OFFS_W-BPP_W){1'b0}}, bpp_reg});
        dst_off_next = OFFS_W'(dst_lin * {{(OFFS_W-BPP_W){1'b0}}, bpp_reg});
    end

    always_ff @(posedge aclk) begin
        if (load[5]) begin
            status5_reg <= status4_reg;
            out_x_reg   <= dx4_reg;
            out_y_reg   <= dy4_reg;
            out_w_reg   <= w4_reg;
            out_h_reg   <= h4_reg;
            src_off_reg <= src_off_next;
            dst_off_reg <= dst_off_next;
            row5_reg    <= row4_reg;
            pat5_reg    <= pat4_reg;
        end
    end

    assign m_valid        = valid_reg[5];
    assign m_status       = status5_reg;
    assign m_out_x        = out_x_reg;
    assign m_out_y        = out_y_reg;
    assign m_out_w        = out_w_reg;
    assign m_out_h        = out_h_reg;
    assign m_src_offset   = src_off_reg;
    assign m_dst_offset   = dst_off_reg;
    assign m_row_bytes    = row5_reg;
    assign m_fill_pattern = pat5_reg;

endmodule

// ===== dv/clip_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clip_result_checker
// Watches the command, result and register ports of the blit/fill clipper.
// Keeps its own copy of the surface registers, predicts the clipped geometry,
// offsets, row length and fill pattern of every accepted command, and compares
// each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module clip_result_checker (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [rbfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rbfc_pkg::DIM_W-1:0]            cfg_data,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic                                  s_cmd,
    input  logic                                  s_use_src_rect,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_src_x,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_src_y,
    input  logic [rbfc_pkg::DIM_W-1:0]            s_rect_w,
    input  logic [rbfc_pkg::DIM_W-1:0]            s_rect_h,
    input  logic                                  s_use_dst_rect,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_dst_x,
    input  logic signed [rbfc_pkg::COORD_W-1:0]   s_dst_y,
    input  logic [rbfc_pkg::COLOR_W-1:0]          s_fill_color,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic                                  m_status,
    input  logic [rbfc_pkg::DIM_W-1:0]            m_out_x,
    input  logic [rbfc_pkg::DIM_W-1:0]            m_out_y,
    input  logic [rbfc_pkg::DIM_W-1:0]            m_out_w,
    input  logic [rbfc_pkg::DIM_W-1:0]            m_out_h,
    input  logic [rbfc_pkg::OFFS_W-1:0]           m_src_offset,
    input  logic [rbfc_pkg::OFFS_W-1:0]           m_dst_offset,
    input  logic [rbfc_pkg::ROW_W-1:0]            m_row_bytes,
    input  logic [rbfc_pkg::COLOR_W-1:0]          m_fill_pattern,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    checked,
    output int                                    fill_rejects,
    output int                                    empty_blits
);
    localparam int DIM_W   = rbfc_pkg::DIM_W;
    localparam int COORD_W = rbfc_pkg::COORD_W;
    localparam int OFFS_W  = rbfc_pkg::OFFS_W;
    localparam int ROW_W   = rbfc_pkg::ROW_W;
    localparam int COLOR_W = rbfc_pkg::COLOR_W;
    localparam int BPP_W   = rbfc_pkg::BPP_W;
    localparam int MAX_DIM = rbfc_pkg::MAX_DIM;

    localparam logic CMD_BLIT      = rbfc_pkg::CMD_BLIT;
    localparam logic CMD_FILL      = rbfc_pkg::CMD_FILL;
    localparam logic STATUS_BOUNDS = rbfc_pkg::STATUS_BOUNDS;

    localparam logic [rbfc_pkg::CFG_IDX_W-1:0] REG_SRC_WIDTH  = rbfc_pkg::REG_SRC_WIDTH;
    localparam logic [rbfc_pkg::CFG_IDX_W-1:0] REG_SRC_HEIGHT = rbfc_pkg::REG_SRC_HEIGHT;
    localparam logic [rbfc_pkg::CFG_IDX_W-1:0] REG_DST_WIDTH  = rbfc_pkg::REG_DST_WIDTH;
    localparam logic [rbfc_pkg::CFG_IDX_W-1:0] REG_DST_HEIGHT = rbfc_pkg::REG_DST_HEIGHT;
    localparam logic [rbfc_pkg::CFG_IDX_W-1:0] REG_BPP        = rbfc_pkg::REG_BPP;

    typedef rbfc_pkg::dim_t dim_t;

    localparam dim_t DIM_LIMIT = MAX_DIM;

    typedef struct packed {
        logic               status;
        dim_t               out_x;
        dim_t               out_y;
        dim_t               out_w;
        dim_t               out_h;
        logic [OFFS_W-1:0]  src_offset;
        logic [OFFS_W-1:0]  dst_offset;
        logic [ROW_W-1:0]   row_bytes;
        logic [COLOR_W-1:0] fill_pattern;
    } clip_result_t;

    dim_t             surf_src_w = 11'd320;
    dim_t             surf_src_h = 11'd240;
    dim_t             surf_dst_w = 11'd320;
    dim_t             surf_dst_h = 11'd240;
    logic [BPP_W-1:0] surf_bpp   = 3'd4;

    clip_result_t clip_results_q[$];
    int           fail_count   = 0;
    int           result_count = 0;
    int           reject_count = 0;
    int           empty_count  = 0;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        checked      = 0;
        fill_rejects = 0;
        empty_blits  = 0;
    end

    function automatic dim_t clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_LIMIT) ? DIM_LIMIT : v;
    endfunction

    function automatic logic [OFFS_W-1:0] pixel_offset(input int x, input int y,
                                                        input int width, input int bpp);
        longint o;
        o = (longint'(y) * width + x) * bpp;
        return o[OFFS_W-1:0];
    endfunction

    function automatic clip_result_t predict_clip(
        input logic                       kind,
        input logic                       has_src,
        input logic signed [COORD_W-1:0]  in_sx,
        input logic signed [COORD_W-1:0]  in_sy,
        input logic [DIM_W-1:0]           in_w,
        input logic [DIM_W-1:0]           in_h,
        input logic                       has_dst,
        input logic signed [COORD_W-1:0]  in_dx,
        input logic signed [COORD_W-1:0]  in_dy,
        input logic [COLOR_W-1:0]         color
    );
        clip_result_t r;
        int sw, sh, dw, dh, bpp;
        int sx, sy, w, h, dx, dy, rb;
        r   = '0;
        sw  = surf_src_w;
        sh  = surf_src_h;
        dw  = surf_dst_w;
        dh  = surf_dst_h;
        bpp = surf_bpp;
        sx  = 0;
        sy  = 0;
        dx  = 0;
        dy  = 0;
        if (kind == CMD_FILL) begin
            w = dw;
            h = dh;
            if (has_dst) begin
                dx = in_dx;
                dy = in_dy;
                w  = in_w;
                h  = in_h;
                if (dx < 0 || dx + w > dw || dy < 0 || dy + h > dh) begin
                    r.status = STATUS_BOUNDS;
                    return r;
                end
            end
            if (bpp == 0)
                r.fill_pattern = '0;
            else if (bpp >= 4)
                r.fill_pattern = color;
            else
                r.fill_pattern = color & ((32'd1 << (8 * bpp)) - 32'd1);
        end else begin
            w = sw;
            h = sh;
            if (has_src) begin
                sx = in_sx;
                sy = in_sy;
                w  = in_w;
                h  = in_h;
            end
            if (has_dst) begin
                dx = in_dx;
                dy = in_dy;
            end
            // a negative corner on one surface moves the other and shrinks the size
            if (sx < 0) begin
                w  = w + sx;
                dx = dx - sx;
                sx = 0;
            end
            if (sy < 0) begin
                h  = h + sy;
                dy = dy - sy;
                sy = 0;
            end
            if (sx + w > sw) w = sw - sx;
            if (sy + h > sh) h = sh - sy;
            if (dx < 0) begin
                w  = w + dx;
                sx = sx - dx;
                dx = 0;
            end
            if (dy < 0) begin
                h  = h + dy;
                sy = sy - dy;
                dy = 0;
            end
            if (dx + w > dw) w = dw - dx;
            if (dy + h > dh) h = dh - dy;
            if (w <= 0 || h <= 0) return r;
            r.src_offset = pixel_offset(sx, sy, sw, bpp);
        end
        rb           = w * bpp;
        r.out_x      = dx[DIM_W-1:0];
        r.out_y      = dy[DIM_W-1:0];
        r.out_w      = w[DIM_W-1:0];
        r.out_h      = h[DIM_W-1:0];
        r.dst_offset = pixel_offset(dx, dy, dw, bpp);
        r.row_bytes  = rb[ROW_W-1:0];
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        clip_result_t want;
        if (!aresetn) begin
            surf_src_w = 11'd320;
            surf_src_h = 11'd240;
            surf_dst_w = 11'd320;
            surf_dst_h = 11'd240;
            surf_bpp   = 3'd4;
            clip_results_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SRC_WIDTH:  surf_src_w = clamp_dim(cfg_data);
                    REG_SRC_HEIGHT: surf_src_h = clamp_dim(cfg_data);
                    REG_DST_WIDTH:  surf_dst_w = clamp_dim(cfg_data);
                    REG_DST_HEIGHT: surf_dst_h = clamp_dim(cfg_data);
                    REG_BPP:        surf_bpp   = cfg_data[BPP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                want = predict_clip(s_cmd, s_use_src_rect, s_src_x, s_src_y, s_rect_w,
                                    s_rect_h, s_use_dst_rect, s_dst_x, s_dst_y,
                                    s_fill_color);
                if (want.status == STATUS_BOUNDS) reject_count++;
                if (s_cmd == CMD_BLIT && want.out_w == 0) empty_count++;
                clip_results_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (clip_results_q.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result transaction with nothing expected: expected none, "
                             , $time, "actual x=%0d y=%0d w=%0d h=%0d",
                             m_out_x, m_out_y, m_out_w, m_out_h);
                end else begin
                    want = clip_results_q.pop_front();
                    result_count++;
                    compare_field("status",       want.status,       m_status);
                    compare_field("out_x",        want.out_x,        m_out_x);
                    compare_field("out_y",        want.out_y,        m_out_y);
                    compare_field("out_w",        want.out_w,        m_out_w);
                    compare_field("out_h",        want.out_h,        m_out_h);
                    compare_field("src_offset",   want.src_offset,   m_src_offset);
                    compare_field("dst_offset",   want.dst_offset,   m_dst_offset);
                    compare_field("row_bytes",    want.row_bytes,    m_row_bytes);
                    compare_field("fill_pattern", want.fill_pattern, m_fill_pattern);
                end
            end
        end
        mismatches   <= fail_count;
        outstanding  <= clip_results_q.size();
        checked      <= result_count;
        fill_rejects <= reject_count;
        empty_blits  <= empty_count;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the rectangle blit/fill clipper. Runs a directed
// set of edge-case blits and fills at the reset surface sizes, then random
// commands over a range of surface settings, with random idling on both
// channels and long result-side hold-offs. Checking lives in the checker.
// ----------------------------------------------------------------------------
module testbench;
    localparam int CFG_IDX_W = rbfc_pkg::CFG_IDX_W;
    localparam int COORD_W   = rbfc_pkg::COORD_W;
    localparam int DIM_W     = rbfc_pkg::DIM_W;
    localparam int COLOR_W   = rbfc_pkg::COLOR_W;
    localparam int OFFS_W    = rbfc_pkg::OFFS_W;
    localparam int ROW_W     = rbfc_pkg::ROW_W;
    localparam int MAX_DIM   = rbfc_pkg::MAX_DIM;

    localparam logic CMD_BLIT = rbfc_pkg::CMD_BLIT;
    localparam logic CMD_FILL = rbfc_pkg::CMD_FILL;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = rbfc_pkg::REG_SRC_WIDTH;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = rbfc_pkg::REG_SRC_HEIGHT;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = rbfc_pkg::REG_DST_WIDTH;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = rbfc_pkg::REG_DST_HEIGHT;
    localparam logic [CFG_IDX_W-1:0] REG_BPP        = rbfc_pkg::REG_BPP;

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int LONG_HOLD    = 60;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

    typedef struct packed {
        logic               kind;
        logic               use_src;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic               use_dst;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [COLOR_W-1:0] color;
    } clip_cmd_t;

    logic                       aclk;
    logic                       aresetn        = 1'b0;
    logic                       cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [DIM_W-1:0]           cfg_data       = '0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic                       s_cmd          = 1'b0;
    logic                       s_use_src_rect = 1'b0;
    logic signed [COORD_W-1:0]  s_src_x        = '0;
    logic signed [COORD_W-1:0]  s_src_y        = '0;
    logic [DIM_W-1:0]           s_rect_w       = '0;
    logic [DIM_W-1:0]           s_rect_h       = '0;
    logic                       s_use_dst_rect = 1'b0;
    logic signed [COORD_W-1:0]  s_dst_x        = '0;
    logic signed [COORD_W-1:0]  s_dst_y        = '0;
    logic [COLOR_W-1:0]         s_fill_color   = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic                       m_status;
    logic [DIM_W-1:0]           m_out_x;
    logic [DIM_W-1:0]           m_out_y;
    logic [DIM_W-1:0]           m_out_w;
    logic [DIM_W-1:0]           m_out_h;
    logic [OFFS_W-1:0]          m_src_offset;
    logic [OFFS_W-1:0]          m_dst_offset;
    logic [ROW_W-1:0]           m_row_bytes;
    logic [COLOR_W-1:0]         m_fill_pattern;

    int  mismatches;
    int  outstanding;
    int  checked;
    int  fill_rejects;
    int  empty_blits;
    int  cycle_count = 0;
    int  blits       = 0;
    int  fills       = 0;
    int  settings    = 1;
    bit  hold_req    = 1'b0;
    bit  quiet       = 1'b0;

    // surface sizes as the block sees them, used to aim the random commands
    int  cur_sw = 320;
    int  cur_sh = 240;
    int  cur_dw = 320;
    int  cur_dh = 240;

    rect_blit_fill_clipper DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_use_src_rect (s_use_src_rect),
        .s_src_x        (s_src_x),
        .s_src_y        (s_src_y),
        .s_rect_w       (s_rect_w),
        .s_rect_h       (s_rect_h),
        .s_use_dst_rect (s_use_dst_rect),
        .s_dst_x        (s_dst_x),
        .s_dst_y        (s_dst_y),
        .s_fill_color   (s_fill_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_w        (m_out_w),
        .m_out_h        (m_out_h),
        .m_src_offset   (m_src_offset),
        .m_dst_offset   (m_dst_offset),
        .m_row_bytes    (m_row_bytes),
        .m_fill_pattern (m_fill_pattern)
    );

    clip_result_checker result_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_use_src_rect (s_use_src_rect),
        .s_src_x        (s_src_x),
        .s_src_y        (s_src_y),
        .s_rect_w       (s_rect_w),
        .s_rect_h       (s_rect_h),
        .s_use_dst_rect (s_use_dst_rect),
        .s_dst_x        (s_dst_x),
        .s_dst_y        (s_dst_y),
        .s_fill_color   (s_fill_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_x        (m_out_x),
        .m_out_y        (m_out_y),
        .m_out_w        (m_out_w),
        .m_out_h        (m_out_h),
        .m_src_offset   (m_src_offset),
        .m_dst_offset   (m_dst_offset),
        .m_row_bytes    (m_row_bytes),
        .m_fill_pattern (m_fill_pattern),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked),
        .fill_rejects   (fill_rejects),
        .empty_blits    (empty_blits)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t ns: timeout after %0d cycles, %0d results still due",
                 $time, cycle_count, outstanding);
        $display("testbench: FAIL");
        $finish;
    end

    // result side: random ready bursts, long hold-offs on request
    initial begin : result_sink
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (quiet || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                if (quiet)
                    @(posedge aclk);
                else if ($urandom_range(0, 7) == 0)
                    repeat (40) @(posedge aclk);
                else
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    function automatic int near_coord(input int extent);
        if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 4095)) - 2048;
        return int'($urandom_range(0, extent + 64)) - 32;
    endfunction

    function automatic int near_size(input int extent);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 2047);
        return $urandom_range(0, extent + 32);
    endfunction

    function automatic int random_dim();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 0;
                    1:       return 1;
                    2:       return MAX_DIM;
                    default: return 2047;
                endcase
            end
            1:       return $urandom_range(0, 2047);
            default: return $urandom_range(1, MAX_DIM);
        endcase
    endfunction

    function automatic clip_cmd_t random_command();
        clip_cmd_t c;
        int sx, sy, dx, dy, w, h;
        c.kind    = 1'($urandom_range(0, 1));
        c.use_src = ($urandom_range(0, 3) != 0);
        c.use_dst = ($urandom_range(0, 3) != 0);
        c.color   = $urandom;
        sx = near_coord(cur_sw);
        sy = near_coord(cur_sh);
        if (c.kind == CMD_FILL && $urandom_range(0, 1) == 1) begin
            // keep the fill rectangle inside the destination
            dx = $urandom_range(0, cur_dw);
            dy = $urandom_range(0, cur_dh);
            w  = $urandom_range(0, cur_dw - dx);
            h  = $urandom_range(0, cur_dh - dy);
        end else begin
            dx = near_coord(cur_dw);
            dy = near_coord(cur_dh);
            w  = near_size(c.kind == CMD_FILL ? cur_dw : cur_sw);
            h  = near_size(c.kind == CMD_FILL ? cur_dh : cur_sh);
        end
        c.sx = sx[COORD_W-1:0];
        c.sy = sy[COORD_W-1:0];
        c.dx = dx[COORD_W-1:0];
        c.dy = dy[COORD_W-1:0];
        c.w  = w[DIM_W-1:0];
        c.h  = h[DIM_W-1:0];
        return c;
    endfunction

    // offer one command and hold it until the transaction completes
    task automatic push_cmd(input clip_cmd_t c);
        s_valid        <= 1'b1;
        s_cmd          <= c.kind;
        s_use_src_rect <= c.use_src;
        s_src_x        <= c.sx;
        s_src_y        <= c.sy;
        s_rect_w       <= c.w;
        s_rect_h       <= c.h;
        s_use_dst_rect <= c.use_dst;
        s_dst_x        <= c.dx;
        s_dst_y        <= c.dy;
        s_fill_color   <= c.color;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (c.kind == CMD_FILL) fills++;
        else blits++;
    endtask

    task automatic issue(input logic kind, input logic use_src, input int sx, input int sy,
                         input int w, input int h, input logic use_dst, input int dx,
                         input int dy, input logic [COLOR_W-1:0] color);
        clip_cmd_t c;
        c.kind    = kind;
        c.use_src = use_src;
        c.sx      = sx[COORD_W-1:0];
        c.sy      = sy[COORD_W-1:0];
        c.w       = w[DIM_W-1:0];
        c.h       = h[DIM_W-1:0];
        c.use_dst = use_dst;
        c.dx      = dx[COORD_W-1:0];
        c.dy      = dy[COORD_W-1:0];
        c.color   = color;
        push_cmd(c);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[DIM_W-1:0];
        @(posedge aclk);
    endtask

    // drain the block, then load a new set of surface registers
    task automatic program_surfaces(input int sw, input int sh, input int dw, input int dh,
                                    input int bpp_data);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        @(posedge aclk);
        write_reg(REG_SRC_WIDTH,  sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH,  dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_BPP,        bpp_data);
        write_reg(CFG_IDX_W'(REG_SPARE_FIRST + $urandom_range(0, 2)),
                  $urandom_range(0, 2047));
        cfg_wr_en <= 1'b0;
        cur_sw = (sw[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : sw[DIM_W-1:0];
        cur_sh = (sh[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : sh[DIM_W-1:0];
        cur_dw = (dw[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : dw[DIM_W-1:0];
        cur_dh = (dh[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : dh[DIM_W-1:0];
        settings++;
    endtask

    task automatic run_random(input int count);
        int gap_odds;
        gap_odds = $urandom_range(0, 4);    // zero: back to back for the whole phase
        repeat (count) begin
            if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            push_cmd(random_command());
        end
    endtask

    initial begin : stimulus
        int p;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge cases at the reset surfaces: 320x240, four bytes per pixel
        issue(CMD_BLIT, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0, 32'h0);
        issue(CMD_BLIT, 1'b1, 10, 20, 100, 50, 1'b1, 30, 40, 32'hFFFF_FFFF);
        issue(CMD_BLIT, 1'b1, -2048, -2048, 2047, 2047, 1'b1, 5, 5, 32'h0);
        issue(CMD_BLIT, 1'b1, -10, -5, 50, 40, 1'b1, 0, 0, 32'h1234_5678);
        issue(CMD_BLIT, 1'b1, 0, 0, 100, 100, 1'b1, -2048, -2048, 32'h0);
        issue(CMD_BLIT, 1'b1, 0, 0, 100, 100, 1'b1, -20, -30, 32'h0);
        issue(CMD_BLIT, 1'b1, 2047, 2047, 10, 10, 1'b1, 0, 0, 32'h0);
        issue(CMD_BLIT, 1'b1, 0, 0, 10, 10, 1'b1, 2047, 2047, 32'h0);
        issue(CMD_BLIT, 1'b1, 0, 0, 2047, 2047, 1'b1, 0, 0, 32'h0);
        issue(CMD_BLIT, 1'b1, 5, 5, 0, 10, 1'b1, 0, 0, 32'h0);
        issue(CMD_BLIT, 1'b0, 0, 0, 0, 0, 1'b1, 300, 200, 32'h0);
        issue(CMD_BLIT, 1'b1, 300, 220, 100, 100, 1'b0, 50, 50, 32'h0);
        issue(CMD_FILL, 1'b0, 0, 0, 0, 0, 1'b0, 0, 0, 32'hDEAD_BEEF);
        issue(CMD_FILL, 1'b1, 7, 9, 100, 50, 1'b1, 10, 20, 32'hFFFF_FFFF);
        issue(CMD_FILL, 1'b0, 0, 0, 10, 10, 1'b1, -1, 0, 32'h55AA_55AA);
        issue(CMD_FILL, 1'b0, 0, 0, 10, 10, 1'b1, 2047, 0, 32'h0);
        issue(CMD_FILL, 1'b0, 0, 0, 21, 10, 1'b1, 300, 0, 32'h0);
        issue(CMD_FILL, 1'b0, 0, 0, 20, 10, 1'b1, 300, 0, 32'hA5A5_A5A5);
        issue(CMD_FILL, 1'b0, 0, 0, 5, 2, 1'b1, 0, 239, 32'h0);
        issue(CMD_FILL, 1'b0, 0, 0, 0, 0, 1'b1, 320, 240, 32'h0F0F_0F0F);
        issue(CMD_FILL, 1'b0, 0, 0, 0, 10, 1'b1, 5, 7, 32'h0);
        issue(CMD_FILL, 1'b0, 0, 0, 10, 10, 1'b1, 0, -2048, 32'h0);
        issue(CMD_FILL, 1'b0, 0, 0, 2047, 2047, 1'b1, 0, 0, 32'h0);

        // hold the result side off while commands keep coming
        s_valid <= 1'b0;
        hold_req = 1'b1;
        wait (!hold_req);
        repeat (30) push_cmd(random_command());

        program_surfaces(1, 1, MAX_DIM, MAX_DIM, 1);
        run_random(40);
        program_surfaces(MAX_DIM, MAX_DIM, 1, 1, 4);
        run_random(40);
        program_surfaces(0, 0, 2047, 1500, 0);
        run_random(40);
        program_surfaces(1500, 2047, 0, 5, 7);
        run_random(40);
        program_surfaces(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM, 5);
        run_random(40);
        program_surfaces(640, 480, 320, 240, 2);
        run_random(40);
        for (p = 0; p < 6; p++) begin
            program_surfaces(random_dim(), random_dim(), random_dim(), random_dim(),
                             $urandom_range(0, 2047));
            if (p == 2) hold_req = 1'b1;
            if (p == 5) quiet = 1'b1;
            run_random(55);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d commands (%0d blits, %0d fills) over %0d surface settings",
                 blits + fills, blits, fills, settings);
        $display("summary: %0d results checked, %0d fills out of bounds, %0d blits clipped away",
                 checked, fill_rejects, empty_blits);
        if (mismatches == 0 && outstanding == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
